### design/orcpe_pkg.sv
package orcpe_pkg;

  localparam int TICK_W   = 21;
  localparam int BASE_W   = 16;
  localparam int BITS_W   = 7;
  localparam int BYTE_W   = 8;
  localparam int RATIO_W  = 5;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 64;

  localparam logic [1:0] PH_SYNC_HI = 2'd0;
  localparam logic [1:0] PH_SYNC_LO = 2'd1;
  localparam logic [1:0] PH_BIT_HI  = 2'd2;
  localparam logic [1:0] PH_BIT_LO  = 2'd3;

  localparam logic [CFG_AW-1:0] REG_CODE_WORD = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CODE_BITS = 3'd1;
  localparam logic [CFG_AW-1:0] REG_BASE      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_PROTOCOL  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_REPEAT    = 3'd4;

  localparam logic [BASE_W-1:0] DEF_BASE    = 16'd350;
  localparam logic [BYTE_W-1:0] DEF_REPEAT  = 8'd10;
  localparam logic [BITS_W-1:0] RST_BITS    = 7'd24;
  localparam logic [BYTE_W-1:0] RST_PROTO   = 8'd11;
  localparam logic [BYTE_W-1:0] PROTO_ONE   = 8'd1;
  localparam logic [BYTE_W-1:0] PROTO_TWO   = 8'd2;

  localparam logic [RATIO_W-1:0] RATIO_UNIT     = 5'd1;
  localparam logic [RATIO_W-1:0] RATIO_SYNC_P1  = 5'd31;
  localparam logic [RATIO_W-1:0] RATIO_SYNC_P2  = 5'd10;
  localparam logic [RATIO_W-1:0] RATIO_SYNC_DEF = 5'd23;
  localparam logic [RATIO_W-1:0] RATIO_BIG_P1   = 5'd3;
  localparam logic [RATIO_W-1:0] RATIO_BIG_DEF  = 5'd2;

  typedef struct packed {
    logic [BITS_W-1:0] code_bits;
    logic [BASE_W-1:0] base_period_us;
    logic [BYTE_W-1:0] protocol;
    logic [BYTE_W-1:0] repeat_count;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic start_rejected;
  } result_t;

endpackage

### design/orcpe_cfg.sv
module orcpe_cfg
  import orcpe_pkg::*;
#(
  parameter int KEY_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_AW-1:0]    cfg_addr,
  input  logic [CFG_DW-1:0]    cfg_wdata,
  output cfg_t                 cfg,
  output logic [KEY_WIDTH-1:0] code_word
);

  logic [KEY_WIDTH-1:0] code_word_r;
  cfg_t                 cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_word_r          <= '0;
      cfg_r.code_bits      <= RST_BITS;
      cfg_r.base_period_us <= DEF_BASE;
      cfg_r.protocol       <= RST_PROTO;
      cfg_r.repeat_count   <= DEF_REPEAT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CODE_WORD: code_word_r          <= cfg_wdata[KEY_WIDTH-1:0];
        REG_CODE_BITS: cfg_r.code_bits      <= cfg_wdata[BITS_W-1:0];
        REG_BASE:      cfg_r.base_period_us <= cfg_wdata[BASE_W-1:0];
        REG_PROTOCOL:  cfg_r.protocol       <= cfg_wdata[BYTE_W-1:0];
        REG_REPEAT:    cfg_r.repeat_count   <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg       = cfg_r;
  assign code_word = code_word_r;

endmodule

### design/orcpe_phase_len.sv
module orcpe_phase_len
  import orcpe_pkg::*;
(
  input  logic [1:0]        phase,
  input  logic              bit_one,
  input  logic [BYTE_W-1:0] protocol,
  input  logic [BASE_W-1:0] base_unit,
  output logic [TICK_W-1:0] len
);

  logic [RATIO_W-1:0] ratio;
  logic [RATIO_W-1:0] big;

  always_comb begin
    big = (protocol == PROTO_ONE) ? RATIO_BIG_P1 : RATIO_BIG_DEF;
    unique case (phase)
      PH_SYNC_HI: ratio = RATIO_UNIT;
      PH_SYNC_LO: begin
        if (protocol == PROTO_ONE)      ratio = RATIO_SYNC_P1;
        else if (protocol == PROTO_TWO) ratio = RATIO_SYNC_P2;
        else                            ratio = RATIO_SYNC_DEF;
      end
      PH_BIT_HI:  ratio = bit_one ? big : RATIO_UNIT;
      PH_BIT_LO:  ratio = bit_one ? RATIO_UNIT : big;
      default:    ratio = RATIO_UNIT;
    endcase
  end

  assign len = {{(TICK_W-BASE_W){1'b0}}, base_unit} * {{(TICK_W-RATIO_W){1'b0}}, ratio};

endmodule

### design/orcpe_seq.sv
module orcpe_seq
  import orcpe_pkg::*;
#(
  parameter int KEY_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tick,
  input  logic                 start_req,
  input  cfg_t                 cfg,
  input  logic [KEY_WIDTH-1:0] code_word,
  output result_t              res
);

  localparam int POS_W = (KEY_WIDTH > 1) ? $clog2(KEY_WIDTH) : 1;

  logic              active_r, active_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] frames_r, frames_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;

  logic [BASE_W-1:0] base_unit;
  logic [BITS_W-1:0] nb;
  logic [BITS_W-1:0] nb_m1;
  logic              start_go, launch, rej;
  logic              cur_active;
  logic [1:0]        cur_phase, ld_phase;
  logic [POS_W-1:0]  cur_pos, ld_pos;
  logic [BYTE_W-1:0] cur_frames, frames_dec;
  logic [TICK_W-1:0] cur_ticks, len;
  logic              load, done;

  always_comb begin
    base_unit = (cfg.base_period_us == '0) ? DEF_BASE : cfg.base_period_us;
    nb        = (cfg.code_bits > BITS_W'(KEY_WIDTH)) ? BITS_W'(KEY_WIDTH) : cfg.code_bits;
    nb_m1     = nb - 1'b1;
    start_go  = !active_r && start_req;
    rej       = start_go && (nb == '0);
    launch    = start_go && (nb != '0);

    cur_active = active_r || launch;
    cur_phase  = launch ? PH_SYNC_HI : phase_r;
    cur_pos    = launch ? '0 : pos_r;
    if (launch) cur_frames = (cfg.repeat_count == '0) ? DEF_REPEAT : cfg.repeat_count;
    else        cur_frames = frames_r;
    cur_ticks  = launch ? {{(TICK_W-BASE_W){1'b0}}, base_unit} : ticks_r;
    frames_dec = cur_frames - 1'b1;

    active_nxt = cur_active;
    phase_nxt  = cur_phase;
    pos_nxt    = cur_pos;
    frames_nxt = cur_frames;
    ticks_nxt  = cur_ticks;
    ld_phase   = cur_phase;
    ld_pos     = cur_pos;
    load       = 1'b0;
    done       = 1'b0;

    if (cur_active) begin
      if (cur_ticks > TICK_W'(1)) begin
        ticks_nxt = cur_ticks - 1'b1;
      end else begin
        unique case (cur_phase)
          PH_SYNC_HI: begin
            ld_phase = PH_SYNC_LO;
            load     = 1'b1;
          end
          PH_SYNC_LO: begin
            ld_pos   = (nb != '0) ? nb_m1[POS_W-1:0] : '0;
            ld_phase = PH_BIT_HI;
            load     = 1'b1;
          end
          PH_BIT_HI: begin
            ld_phase = PH_BIT_LO;
            load     = 1'b1;
          end
          PH_BIT_LO: begin
            if (cur_pos != '0) begin
              ld_pos   = cur_pos - 1'b1;
              ld_phase = PH_BIT_HI;
              load     = 1'b1;
            end else if (frames_dec == '0) begin
              frames_nxt = '0;
              active_nxt = 1'b0;
              done       = 1'b1;
              phase_nxt  = PH_SYNC_HI;
              ticks_nxt  = '0;
            end else begin
              frames_nxt = frames_dec;
              ld_phase   = PH_SYNC_HI;
              load       = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    if (load) begin
      phase_nxt = ld_phase;
      pos_nxt   = ld_pos;
      ticks_nxt = len;
    end

    res.line_level     = cur_active && !cur_phase[0];
    res.busy_res       = cur_active;
    res.frame_done     = done;
    res.start_rejected = rej;
  end

  orcpe_phase_len u_len (
    .phase     (ld_phase),
    .bit_one   (code_word[ld_pos]),
    .protocol  (cfg.protocol),
    .base_unit (base_unit),
    .len       (len)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phase_r  <= PH_SYNC_HI;
      pos_r    <= '0;
      frames_r <= '0;
      ticks_r  <= '0;
    end else if (tick) begin
      active_r <= active_nxt;
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      frames_r <= frames_nxt;
      ticks_r  <= ticks_nxt;
    end
  end

endmodule

### design/orcpe_out_reg.sv
module orcpe_out_reg
  import orcpe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r;
  result_t res_r;

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### design/ook_remote_code_pulse_encoder.sv
// OOK remote-control code pulse encoder.
// Input stream: one transaction per microsecond tick; in_tdata[0] is start_req.
// Output stream: one transaction per input transaction, in order, carrying the
// keyed line level for that microsecond, busy, and the start-rejected flag;
// out_tlast marks the final microsecond of a whole transmission.
// Config port: cfg_we writes register cfg_addr (0 code_word, 1 code_bits,
// 2 base_period_us, 3 protocol, 4 repeat_count) with cfg_wdata; write only
// while the block is idle.
// The result of a tick is registered and is valid in the cycle after it is accepted.
// Throughput: one tick per cycle while in_tready is high; the per-tick path is
// the phase counter update plus one 16x5 multiply for the next phase length.
// Reset (rst_n low, synchronous): the encoder goes idle, the line is low and
// the config registers return to 0, 24, 350, 11, 10.
// Back-pressure: a single output register holds the pending result; in_tready
// drops only while that register is full and out_tready is low.
module ook_remote_code_pulse_encoder
  import orcpe_pkg::*;
#(
  parameter int KEY_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [0] start_req, [7:1] zero
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [0] line_level, [1] busy_res, [2] start_rejected
  output logic              out_tlast,  // frame_done
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t                 cfg;
  logic [KEY_WIDTH-1:0] code_word;
  result_t              res;
  result_t              out_res;
  logic                 tick;

  assign tick = in_tvalid && in_tready;

  orcpe_cfg #(.KEY_WIDTH(KEY_WIDTH)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .code_word (code_word)
  );

  orcpe_seq #(.KEY_WIDTH(KEY_WIDTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .start_req (in_tdata[0]),
    .cfg       (cfg),
    .code_word (code_word),
    .res       (res)
  );

  orcpe_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {5'd0, out_res.start_rejected, out_res.busy_res, out_res.line_level};
  assign out_tlast = out_res.frame_done;

endmodule

### design/orcpe_checker.sv
module orcpe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_line_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("line keyed while not busy");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[1] && !out_tdata[2])
    else $error("transmission end without busy");

  a_reject_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[1] && !out_tdata[0] && !out_tlast)
    else $error("rejected start while busy");

endmodule

bind ook_remote_code_pulse_encoder orcpe_checker u_orcpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
